// ----- hdl/ntp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_pkg
// Types, codes and constants shared by the numeric text parser files.
// ----------------------------------------------------------------------------
package ntp_pkg;

    localparam int NUM_SYMBOLS = 32;
    localparam int SYMBOL_W    = 8;
    localparam int ACC_W       = 32;   // low half of the wrapping accumulator
    localparam int COUNT_W     = 6;
    localparam int DIGIT_W     = 5;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 4;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_DIGIT_COUNT = 3'd0;
    localparam cfg_index_t REG_ALPHA_WORD0 = 3'd1;
    localparam cfg_index_t REG_ALPHA_WORD1 = 3'd2;
    localparam cfg_index_t REG_ALPHA_WORD2 = 3'd3;
    localparam cfg_index_t REG_ALPHA_WORD3 = 3'd4;

    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 6'd10;
    localparam logic [WORD_W-1:0]  ALPHA_WORD0_RST = 64'h3736_3534_3332_3130;
    localparam logic [WORD_W-1:0]  ALPHA_WORD1_RST = 64'h0000_0000_0000_3938;
    localparam logic [WORD_W-1:0]  ALPHA_WORD2_RST = 64'h0;
    localparam logic [WORD_W-1:0]  ALPHA_WORD3_RST = 64'h0;

    localparam logic [SYMBOL_W-1:0] CH_NUL   = 8'd0;
    localparam logic [SYMBOL_W-1:0] CH_TAB   = 8'd9;
    localparam logic [SYMBOL_W-1:0] CH_CR    = 8'd13;
    localparam logic [SYMBOL_W-1:0] CH_SPACE = 8'd32;
    localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                final_char;
    } char_t;

    typedef struct packed {
        logic signed [31:0] parsed_value;
        logic               alphabet_invalid;
    } result_t;

    typedef struct packed {
        cfg_index_t          index;
        logic [WORD_W-1:0]   data;
    } cfg_t;

    function automatic logic is_space(input logic [SYMBOL_W-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

// ----- hdl/ntp_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface ntp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- hdl/numeric_text_parser_any_base_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_text_parser_any_base_unit
// Streaming string-to-integer parser with a configurable digit alphabet.
// ----------------------------------------------------------------------------
//  channel  dir  payload                           request completes on
//  text     in   symbol[7:0], final_char           text.valid & text.ready
//  result   out  parsed_value[31:0], alph_invalid  result.valid & result.ready
//  cfg      in   index[2:0], data[63:0]            cfg.valid (ready tied high)
//
//  One character per cycle. A character is registered, then the alphabet
//  match, sign/phase logic and one 32x6 multiply-add update the state.
//  A final character waits in the input register, then its result is registered.
//  text.ready drops only while a final character waits on a full result reg.
//  Reset restores the default decimal alphabet and clears the parse state.
// ----------------------------------------------------------------------------
module numeric_text_parser_any_base_unit #(
    parameter int MAX_DIGITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ntp_stream_if.sink    text,
    ntp_stream_if.source  result,
    ntp_stream_if.sink    cfg
);

    // configuration
    logic [ntp_pkg::COUNT_W-1:0]                         dc_reg;
    logic [ntp_pkg::NUM_WORDS-1:0][ntp_pkg::WORD_W-1:0]  alpha_reg;
    logic [ntp_pkg::NUM_SYMBOLS*ntp_pkg::SYMBOL_W-1:0]   alpha_flat;
    logic                                                alpha_bad;

    // input register
    logic                          s1_valid_reg;
    logic [ntp_pkg::SYMBOL_W-1:0]  sym_reg;
    logic                          fin_reg;
    logic                          s1_fire;

    // parse state
    ntp_pkg::phase_t               phase_reg, phase_next;
    logic                          neg_reg, neg_next;
    logic [ntp_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [ntp_pkg::ACC_W-1:0]     acc_final;
    logic                          neg_final;

    // lookup
    logic                          hit;
    logic [ntp_pkg::DIGIT_W-1:0]   digit;

    // result register
    logic                          out_valid_reg;
    logic signed [31:0]            value_reg;
    logic                          invalid_reg;

    assign alpha_flat = alpha_reg;
    assign cfg.ready  = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg       <= ntp_pkg::DIGIT_COUNT_RST;
            alpha_reg[0] <= ntp_pkg::ALPHA_WORD0_RST;
            alpha_reg[1] <= ntp_pkg::ALPHA_WORD1_RST;
            alpha_reg[2] <= ntp_pkg::ALPHA_WORD2_RST;
            alpha_reg[3] <= ntp_pkg::ALPHA_WORD3_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                ntp_pkg::REG_DIGIT_COUNT: dc_reg       <= cfg.payload.data[ntp_pkg::COUNT_W-1:0];
                ntp_pkg::REG_ALPHA_WORD0: alpha_reg[0] <= cfg.payload.data;
                ntp_pkg::REG_ALPHA_WORD1: alpha_reg[1] <= cfg.payload.data;
                ntp_pkg::REG_ALPHA_WORD2: alpha_reg[2] <= cfg.payload.data;
                ntp_pkg::REG_ALPHA_WORD3: alpha_reg[3] <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    // Alphabet check on the live registers, so a final character is judged
    // against the same alphabet that its own lookup uses.
    always_comb
    begin
        logic [ntp_pkg::SYMBOL_W-1:0] si;
        logic [ntp_pkg::SYMBOL_W-1:0] sj;
        logic                         use_i;
        logic                         use_j;
        alpha_bad = (dc_reg < ntp_pkg::COUNT_W'(2)) || (32'(dc_reg) > 32'(MAX_DIGITS));
        for (int i = 0; i < ntp_pkg::NUM_SYMBOLS; i++)
        begin
            si    = alpha_flat[i*ntp_pkg::SYMBOL_W +: ntp_pkg::SYMBOL_W];
            use_i = ntp_pkg::COUNT_W'(i) < dc_reg;
            if (use_i && ((si == ntp_pkg::CH_NUL) || (si == ntp_pkg::CH_PLUS) ||
                          (si == ntp_pkg::CH_MINUS) || ntp_pkg::is_space(si)))
                alpha_bad = 1'b1;
            for (int j = i + 1; j < ntp_pkg::NUM_SYMBOLS; j++)
            begin
                sj    = alpha_flat[j*ntp_pkg::SYMBOL_W +: ntp_pkg::SYMBOL_W];
                use_j = ntp_pkg::COUNT_W'(j) < dc_reg;
                if (use_j && (si == sj))
                    alpha_bad = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------- input stage
    assign s1_fire    = s1_valid_reg && (!fin_reg || !out_valid_reg || result.ready);
    assign text.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.valid && text.ready)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            sym_reg <= text.payload.symbol;
            fin_reg <= text.payload.final_char;
        end
    end

    // ------------------------------------------------------ alphabet lookup
    // Lowest matching position wins; the zero byte never matches.
    always_comb
    begin
        hit   = 1'b0;
        digit = '0;
        for (int i = ntp_pkg::NUM_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((i < MAX_DIGITS) && (ntp_pkg::COUNT_W'(i) < dc_reg) &&
                (sym_reg != ntp_pkg::CH_NUL) &&
                (alpha_flat[i*ntp_pkg::SYMBOL_W +: ntp_pkg::SYMBOL_W] == sym_reg))
            begin
                hit   = 1'b1;
                digit = ntp_pkg::DIGIT_W'(i);
            end
        end
    end

    // ---------------------------------------------------------- parse state
    always_comb
    begin
        ntp_pkg::phase_t ph;
        ph        = phase_reg;
        neg_final = neg_reg;
        acc_final = acc_reg;

        if (ph == ntp_pkg::PH_SPACE)
        begin
            if (sym_reg == ntp_pkg::CH_NUL)
                ph = ntp_pkg::PH_STOP;
            else if (!ntp_pkg::is_space(sym_reg))
                ph = ntp_pkg::PH_SIGN;
        end
        if (ph == ntp_pkg::PH_SIGN)
        begin
            if (sym_reg == ntp_pkg::CH_MINUS)
                neg_final = ~neg_reg;
            else if (sym_reg != ntp_pkg::CH_PLUS)
                ph = ntp_pkg::PH_DIGITS;
        end
        if (ph == ntp_pkg::PH_DIGITS)
        begin
            // low 32 bits of the 64-bit wrap depend only on low 32 bits
            if (hit)
                acc_final = acc_reg * ntp_pkg::ACC_W'(dc_reg) + ntp_pkg::ACC_W'(digit);
            else
                ph = ntp_pkg::PH_STOP;
        end

        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (s1_fire)
        begin
            if (fin_reg)
            begin
                phase_next = ntp_pkg::PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                phase_next = ph;
                neg_next   = neg_final;
                acc_next   = acc_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ntp_pkg::PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // ------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && fin_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && fin_reg)
        begin
            invalid_reg <= alpha_bad;
            if (alpha_bad)
                value_reg <= '0;
            else if (neg_final)
                value_reg <= $signed(ntp_pkg::ACC_W'(0) - acc_final);
            else
                value_reg <= $signed(acc_final);
        end
    end

    assign result.valid                    = out_valid_reg;
    assign result.payload.parsed_value     = value_reg;
    assign result.payload.alphabet_invalid = invalid_reg;

    // ----------------------------------------------------------- assertions
    a_final_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && fin_reg |=> (phase_reg == ntp_pkg::PH_SPACE) && !neg_reg && (acc_reg == '0))
        else $error("parse state not cleared after final character");

    a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> (value_reg == '0))
        else $error("invalid alphabet result is not zero");

    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ntp_pkg::PH_STOP) && s1_fire && !fin_reg
        |=> (phase_reg == ntp_pkg::PH_STOP) && $stable(acc_reg))
        else $error("stopped parse changed its accumulator");

    a_short_base_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (dc_reg < ntp_pkg::COUNT_W'(2)) |-> alpha_bad)
        else $error("base below two not flagged");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> s1_valid_reg && fin_reg && out_valid_reg)
        else $error("input stalled without a blocked final character");

endmodule

// ----- tb/sv/numeric_text_parser_any_base_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_text_parser_any_base_unit_test
// Self-checking bench for the streaming any-base text parser. Strings go in
// one character per request; a scoreboard tracks the parse state and the
// alphabet registers and predicts each result. Alphabets are changed between
// phases: narrow and full bases, bad symbols, duplicates and bad counts.
// ----------------------------------------------------------------------------
class parse_scoreboard;
    logic [ntp_pkg::COUNT_W-1:0] digit_count;
    logic [ntp_pkg::WORD_W-1:0]  alpha_word [ntp_pkg::NUM_WORDS];
    ntp_pkg::phase_t             phase;
    bit                          negative;
    logic [63:0]                 acc;
    ntp_pkg::result_t            pending [$];
    int                          fail_count;
    int                          results_seen;
    int                          invalid_seen;
    int                          negative_seen;

    function new();
        digit_count   = ntp_pkg::DIGIT_COUNT_RST;
        alpha_word[0] = ntp_pkg::ALPHA_WORD0_RST;
        alpha_word[1] = ntp_pkg::ALPHA_WORD1_RST;
        alpha_word[2] = ntp_pkg::ALPHA_WORD2_RST;
        alpha_word[3] = ntp_pkg::ALPHA_WORD3_RST;
        phase         = ntp_pkg::PH_SPACE;
        negative      = 1'b0;
        acc           = '0;
    endfunction

    function logic [ntp_pkg::SYMBOL_W-1:0] symbol_at(int pos);
        return alpha_word[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    function void set_register(ntp_pkg::cfg_index_t idx, logic [ntp_pkg::WORD_W-1:0] value);
        if (idx == ntp_pkg::REG_DIGIT_COUNT)
            digit_count = value[ntp_pkg::COUNT_W-1:0];
        else if (idx >= ntp_pkg::REG_ALPHA_WORD0 && idx <= ntp_pkg::REG_ALPHA_WORD3)
            alpha_word[idx - ntp_pkg::REG_ALPHA_WORD0] = value;
    endfunction

    function void note_char(ntp_pkg::char_t ch);
        logic [ntp_pkg::SYMBOL_W-1:0] c;
        logic [ntp_pkg::SYMBOL_W-1:0] s;
        logic [63:0]                  value;
        int                           n;
        int                           digit;
        bit                           bad;
        ntp_pkg::result_t             want;
        c = ch.symbol;
        n = (digit_count > ntp_pkg::NUM_SYMBOLS) ? ntp_pkg::NUM_SYMBOLS : int'(digit_count);

        if (phase == ntp_pkg::PH_SPACE)
        begin
            if (c == ntp_pkg::CH_NUL)
                phase = ntp_pkg::PH_STOP;
            else if (!ntp_pkg::is_space(c))
                phase = ntp_pkg::PH_SIGN;
        end
        if (phase == ntp_pkg::PH_SIGN)
        begin
            if (c == ntp_pkg::CH_MINUS)
                negative = !negative;
            else if (c != ntp_pkg::CH_PLUS)
                phase = ntp_pkg::PH_DIGITS;
        end
        if (phase == ntp_pkg::PH_DIGITS)
        begin
            // lowest matching position wins
            digit = -1;
            if (c != ntp_pkg::CH_NUL)
                for (int i = n - 1; i >= 0; i--)
                    if (symbol_at(i) == c)
                        digit = i;
            if (digit >= 0)
                acc = acc * {58'd0, digit_count} + 64'(digit);
            else
                phase = ntp_pkg::PH_STOP;
        end

        if (!ch.final_char)
            return;

        bad = (digit_count < 2) || (digit_count > ntp_pkg::NUM_SYMBOLS);
        for (int i = 0; i < n; i++)
        begin
            s = symbol_at(i);
            if (s == ntp_pkg::CH_NUL || s == ntp_pkg::CH_PLUS || s == ntp_pkg::CH_MINUS ||
                ntp_pkg::is_space(s))
                bad = 1'b1;
            for (int j = i + 1; j < n; j++)
                if (symbol_at(j) == s)
                    bad = 1'b1;
        end
        value = negative ? (64'd0 - acc) : acc;
        want.parsed_value     = bad ? '0 : value[31:0];
        want.alphabet_invalid = bad;
        pending.push_back(want);

        phase    = ntp_pkg::PH_SPACE;
        negative = 1'b0;
        acc      = '0;
    endfunction

    function void check_result(ntp_pkg::result_t got);
        ntp_pkg::result_t want;
        results_seen++;
        if (pending.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: value=%0d invalid=%0b",
                         got.parsed_value, got.alphabet_invalid);
            return;
        end
        want = pending.pop_front();
        if (got.parsed_value !== want.parsed_value ||
            got.alphabet_invalid !== want.alphabet_invalid)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result mismatch: value exp %0d got %0d, invalid exp %0b got %0b",
                         want.parsed_value, got.parsed_value,
                         want.alphabet_invalid, got.alphabet_invalid);
        end
        if (want.alphabet_invalid)
            invalid_seen++;
        else if (want.parsed_value < 0)
            negative_seen++;
    endfunction
endclass

module numeric_text_parser_any_base_unit_test;

    localparam int NUM_PHASES      = 14;
    localparam int CHARS_PER_PHASE = 125;

    typedef logic [ntp_pkg::SYMBOL_W-1:0] text_q_t [$];

    typedef enum {
        FLAW_NONE,
        FLAW_DUP,
        FLAW_SIGN,
        FLAW_BLANK,
        FLAW_NUL
    } flaw_t;

    logic clk;
    logic rst_n;

    ntp_stream_if #(.payload_t(ntp_pkg::char_t))   text_ch ();
    ntp_stream_if #(.payload_t(ntp_pkg::result_t)) result_ch ();
    ntp_stream_if #(.payload_t(ntp_pkg::cfg_t))    cfg_ch ();

    numeric_text_parser_any_base_unit #(
        .MAX_DIGITS(ntp_pkg::NUM_SYMBOLS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    parse_scoreboard              sb;
    bit                           idle_on;
    int                           stall_left = 0;
    int                           chars_sent;
    int                           strings_sent;
    int                           settings_done;
    int                           alpha_len;
    logic [ntp_pkg::SYMBOL_W-1:0] alpha_sym [ntp_pkg::NUM_SYMBOLS];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // scoreboard taps: requests are taken on the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
                sb.note_char(text_ch.payload);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.payload);
        end
    end

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 14);
        end
        else
            result_ch.ready <= 1'b1;
    end

    function automatic logic [ntp_pkg::SYMBOL_W-1:0] random_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? ntp_pkg::CH_SPACE : ntp_pkg::CH_TAB + ntp_pkg::SYMBOL_W'(r);
    endfunction

    function automatic logic [ntp_pkg::SYMBOL_W-1:0] pick_digit();
        if (alpha_len == 0)
            return ntp_pkg::SYMBOL_W'($urandom_range(1, 255));
        return alpha_sym[$urandom_range(0, alpha_len - 1)];
    endfunction

    task automatic send_char(input ntp_pkg::char_t ch);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.payload <= ch;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_string(input text_q_t s);
        foreach (s[i])
            send_char('{symbol: s[i], final_char: (i == s.size() - 1)});
        strings_sent++;
    endtask

    task automatic send_random_string();
        text_q_t s;
        int      kind;
        int      ndig;
        kind = $urandom_range(0, 9);
        if (kind < 8)
        begin
            repeat ($urandom_range(0, 3)) s.push_back(random_blank());
            repeat ($urandom_range(0, 3))
                s.push_back($urandom_range(0, 1) ? ntp_pkg::CH_MINUS : ntp_pkg::CH_PLUS);
            // long runs wrap the accumulator
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24)
                                               : $urandom_range(1, 8);
            repeat (ndig) s.push_back(pick_digit());
            if (kind == 7)
            begin
                s.push_back($urandom_range(0, 1) ? ntp_pkg::CH_NUL
                                                 : ntp_pkg::SYMBOL_W'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 4)) s.push_back(pick_digit());
            end
        end
        else
            repeat ($urandom_range(1, 6))
                s.push_back(ntp_pkg::SYMBOL_W'($urandom_range(0, 255)));
        send_string(s);
    endtask

    // leaves valid high so back-to-back writes need one assignment per edge
    task automatic write_reg(input ntp_pkg::cfg_index_t idx,
                             input logic [ntp_pkg::WORD_W-1:0] value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: value};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic program_regs(input logic [ntp_pkg::COUNT_W-1:0] count,
                                input logic [ntp_pkg::WORD_W-1:0] words [ntp_pkg::NUM_WORDS]);
        // upper data bits are don't-care for the count register
        write_reg(ntp_pkg::REG_DIGIT_COUNT, {$urandom, 26'($urandom), count});
        for (int i = 0; i < ntp_pkg::NUM_WORDS; i++)
            write_reg(ntp_pkg::cfg_index_t'(ntp_pkg::REG_ALPHA_WORD0 + i), words[i]);
        if ($urandom_range(0, 1))
            write_reg(ntp_pkg::cfg_index_t'(ntp_pkg::REG_ALPHA_WORD3 + $urandom_range(1, 3)),
                      {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
        alpha_len = (count > ntp_pkg::NUM_SYMBOLS) ? ntp_pkg::NUM_SYMBOLS : int'(count);
        for (int i = 0; i < ntp_pkg::NUM_SYMBOLS; i++)
            alpha_sym[i] = words[i / 8][(i % 8) * 8 +: 8];
        settings_done++;
    endtask

    task automatic build_alphabet(input int count, input flaw_t flaw);
        logic [ntp_pkg::SYMBOL_W-1:0] syms [ntp_pkg::NUM_SYMBOLS];
        logic [ntp_pkg::WORD_W-1:0]   words [ntp_pkg::NUM_WORDS];
        bit                           taken [256];
        logic [ntp_pkg::SYMBOL_W-1:0] c;
        int                           n;
        int                           k;
        int                           j;
        n = (count > ntp_pkg::NUM_SYMBOLS) ? ntp_pkg::NUM_SYMBOLS : count;
        for (int i = 0; i < ntp_pkg::NUM_SYMBOLS; i++)
        begin
            if (i < n)
            begin
                do
                    c = ntp_pkg::SYMBOL_W'($urandom_range(1, 255));
                while (c == ntp_pkg::CH_PLUS || c == ntp_pkg::CH_MINUS ||
                       ntp_pkg::is_space(c) || taken[c]);
                taken[c] = 1'b1;
            end
            else
                c = ntp_pkg::SYMBOL_W'($urandom_range(0, 255));
            syms[i] = c;
        end
        if (n >= 2)
        begin
            k = $urandom_range(0, n - 1);
            j = (k + $urandom_range(1, n - 1)) % n;
            case (flaw)
                FLAW_DUP:   syms[k] = syms[j];
                FLAW_SIGN:  syms[k] = $urandom_range(0, 1) ? ntp_pkg::CH_PLUS
                                                           : ntp_pkg::CH_MINUS;
                FLAW_BLANK: syms[k] = random_blank();
                FLAW_NUL:   syms[k] = ntp_pkg::CH_NUL;
                default:    ;
            endcase
        end
        for (int i = 0; i < ntp_pkg::NUM_SYMBOLS; i++)
            words[i / 8][(i % 8) * 8 +: 8] = syms[i];
        program_regs(ntp_pkg::COUNT_W'(count), words);
    endtask

    task automatic drain();
        int waited;
        text_ch.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (sb.pending.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        // covers the pipeline of non-final characters
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int start;
        sb = new();
        idle_on         <= 1'b1;
        rst_n           <= 1'b0;
        text_ch.valid   <= 1'b0;
        text_ch.payload <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.payload  <= '0;
        alpha_len        = 10;
        for (int i = 0; i < ntp_pkg::NUM_SYMBOLS; i++)
            alpha_sym[i] = (i < 10) ? "0" + ntp_pkg::SYMBOL_W'(i) : ntp_pkg::CH_NUL;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet: blanks, sign runs, stops, zero bytes, most negative value
        send_string('{ntp_pkg::CH_TAB, ntp_pkg::CH_MINUS, "7"});
        send_string('{ntp_pkg::CH_PLUS, ntp_pkg::CH_MINUS, ntp_pkg::CH_PLUS, "9", "z", "1"});
        send_string('{ntp_pkg::CH_NUL, "5"});
        send_string('{"4", ntp_pkg::CH_NUL, "5"});
        send_string('{8'hFF});
        send_string('{ntp_pkg::CH_CR, ntp_pkg::CH_SPACE, ntp_pkg::CH_MINUS});
        send_string('{ntp_pkg::CH_TAB + 8'd2, ntp_pkg::CH_MINUS, "2", "1", "4", "7", "4",
                      "8", "3", "6", "4", "8"});

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            idle_on <= (p < NUM_PHASES - 2);
            case (p)
                0:  build_alphabet(2, FLAW_NONE);
                1:  build_alphabet(ntp_pkg::NUM_SYMBOLS, FLAW_NONE);
                2:  build_alphabet($urandom_range(2, ntp_pkg::NUM_SYMBOLS), FLAW_DUP);
                3:  build_alphabet(0, FLAW_NONE);
                4:  build_alphabet(1, FLAW_NONE);
                5:  build_alphabet(63, FLAW_NONE);
                6:  build_alphabet($urandom_range(2, ntp_pkg::NUM_SYMBOLS), FLAW_SIGN);
                7:  build_alphabet($urandom_range(2, ntp_pkg::NUM_SYMBOLS), FLAW_BLANK);
                8:  build_alphabet($urandom_range(2, ntp_pkg::NUM_SYMBOLS), FLAW_NUL);
                9:  build_alphabet(ntp_pkg::NUM_SYMBOLS + 1, FLAW_NONE);
                10: program_regs(ntp_pkg::DIGIT_COUNT_RST,
                                 '{ntp_pkg::ALPHA_WORD0_RST, ntp_pkg::ALPHA_WORD1_RST,
                                   ntp_pkg::ALPHA_WORD2_RST, ntp_pkg::ALPHA_WORD3_RST});
                default: build_alphabet($urandom_range(2, ntp_pkg::NUM_SYMBOLS), FLAW_NONE);
            endcase
            start = chars_sent;
            while (chars_sent - start < CHARS_PER_PHASE)
                send_random_string();
        end
        drain();

        if (sb.pending.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending.size());
            sb.fail_count += sb.pending.size();
        end
        $display("covered %0d strings (%0d characters) under %0d alphabet settings",
                 strings_sent, chars_sent, settings_done + 1);
        $display("%0d results checked: %0d invalid alphabet, %0d negative, %0d failures",
                 sb.results_seen, sb.invalid_seen, sb.negative_seen, sb.fail_count);
        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting on the parser");
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ntp_pkg.sv
hdl/ntp_stream_if.sv
hdl/numeric_text_parser_any_base_unit.sv
tb/sv/numeric_text_parser_any_base_unit_test.sv
